// ===== design/chp_pkg.sv =====
// types, constants and helpers shared by the rtmp chunk header parser
package chp_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CHAN_W    = 6;
   localparam int unsigned TS_W      = 24;
   localparam int unsigned LEN_W     = 24;
   localparam int unsigned TYPE_W    = 8;
   localparam int unsigned STREAM_W  = 32;
   localparam int unsigned FORM_W    = 2;
   localparam int unsigned POS_W     = 4;

   localparam logic [FORM_W-1:0] FORM_FULL  = 2'd0;
   localparam logic [FORM_W-1:0] FORM_NO_ID = 2'd1;
   localparam logic [FORM_W-1:0] FORM_TS    = 2'd2;
   localparam logic [FORM_W-1:0] FORM_NONE  = 2'd3;

   localparam logic [POS_W-1:0] LEN_FULL  = 4'd12;
   localparam logic [POS_W-1:0] LEN_NO_ID = 4'd8;
   localparam logic [POS_W-1:0] LEN_TS    = 4'd4;
   localparam logic [POS_W-1:0] LEN_NONE  = 4'd1;

   localparam logic [POS_W-1:0] POS_FIRST   = 4'd0;
   localparam logic [POS_W-1:0] POS_TS_LO   = 4'd1;
   localparam logic [POS_W-1:0] POS_TS_HI   = 4'd3;
   localparam logic [POS_W-1:0] POS_LEN_LO  = 4'd4;
   localparam logic [POS_W-1:0] POS_LEN_HI  = 4'd6;
   localparam logic [POS_W-1:0] POS_TYPE    = 4'd7;

   localparam logic [TYPE_W-1:0] TYPE_NULL = 8'd0;

   typedef struct packed {
      logic [CHAN_W-1:0]   chunk_chan;
      logic [TS_W-1:0]     ts_msec;
      logic [LEN_W-1:0]    msg_len;
      logic [TYPE_W-1:0]   msg_type;
      logic [STREAM_W-1:0] msg_stream;
      logic [FORM_W-1:0]   header_form;
      logic                invalid;
   } hdr_result_type;

   function automatic logic [POS_W-1:0] header_len(input logic [FORM_W-1:0] form);
      logic [POS_W-1:0] len;
      case (form)
         FORM_FULL:  len = LEN_FULL;
         FORM_NO_ID: len = LEN_NO_ID;
         FORM_TS:    len = LEN_TS;
         FORM_NONE:  len = LEN_NONE;
         default:    len = LEN_FULL;
      endcase
      return len;
   endfunction

endpackage

// ===== design/chp_intf.sv =====
// handshake channels for header bytes in and decoded headers out
interface chp_req_if;
   logic                      valid;
   logic                      ready;
   logic [chp_pkg::BYTE_W-1:0] header_byte;

   modport source (output valid, output header_byte, input ready);
   modport sink   (input valid, input header_byte, output ready);
endinterface

interface chp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [chp_pkg::CHAN_W-1:0]   chunk_chan;
   logic [chp_pkg::TS_W-1:0]     ts_msec;
   logic [chp_pkg::LEN_W-1:0]    msg_len;
   logic [chp_pkg::TYPE_W-1:0]   msg_type;
   logic [chp_pkg::STREAM_W-1:0] msg_stream;
   logic [chp_pkg::FORM_W-1:0]   header_form;
   logic                         invalid;

   modport source (output valid, output chunk_chan, output ts_msec, output msg_len,
                   output msg_type, output msg_stream, output header_form, output invalid,
                   input ready);
   modport sink   (input valid, input chunk_chan, input ts_msec, input msg_len,
                   input msg_type, input msg_stream, input header_form, input invalid,
                   output ready);
endinterface

// ===== design/chp_field_state.sv =====
// byte position counter and kept header fields, with next-field decode
module chp_field_state (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [chp_pkg::BYTE_W-1:0] byte_in,
   output logic                       done,
   output chp_pkg::hdr_result_type    result
);
   import chp_pkg::*;

   logic [POS_W-1:0]    pos_ff,     pos_in;
   logic [FORM_W-1:0]   form_ff,    form_in;
   logic [CHAN_W-1:0]   channel_ff, channel_in;
   logic [TS_W-1:0]     ts_ff,      ts_in;
   logic [LEN_W-1:0]    len_ff,     len_in;
   logic [TYPE_W-1:0]   type_ff,    type_in;
   logic [STREAM_W-1:0] stream_ff,  stream_in;
   logic [POS_W:0]      pos_plus;

   always_comb begin
      form_in    = form_ff;
      channel_in = channel_ff;
      ts_in      = ts_ff;
      len_in     = len_ff;
      type_in    = type_ff;
      stream_in  = stream_ff;
      case (pos_ff) inside
         POS_FIRST: begin
            form_in    = byte_in[BYTE_W-1 -: FORM_W];
            channel_in = byte_in[CHAN_W-1:0];
         end
         [POS_TS_LO:POS_TS_HI]: begin
            ts_in = {ts_ff[TS_W-BYTE_W-1:0], byte_in};
         end
         [POS_LEN_LO:POS_LEN_HI]: begin
            len_in = {len_ff[LEN_W-BYTE_W-1:0], byte_in};
         end
         POS_TYPE: begin
            type_in = byte_in;
         end
         default: begin
            // little endian: earlier bytes shift down toward the lsb
            stream_in = {byte_in, stream_ff[STREAM_W-1:BYTE_W]};
         end
      endcase
   end

   assign pos_plus = {1'b0, pos_ff} + {{POS_W{1'b0}}, 1'b1};
   assign done     = pos_plus >= {1'b0, header_len(form_in)};
   assign pos_in   = done ? POS_FIRST : pos_plus[POS_W-1:0];

   always_comb begin
      result.chunk_chan  = channel_in;
      result.ts_msec     = ts_in;
      result.msg_len     = len_in;
      result.msg_type    = type_in;
      result.msg_stream  = stream_in;
      result.header_form = form_in;
      result.invalid     = (type_in == TYPE_NULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_FIRST;
         form_ff    <= FORM_FULL;
         channel_ff <= '0;
         ts_ff      <= '0;
         len_ff     <= '0;
         type_ff    <= TYPE_NULL;
         stream_ff  <= '0;
      end else if (step) begin
         pos_ff     <= pos_in;
         form_ff    <= form_in;
         channel_ff <= channel_in;
         ts_ff      <= ts_in;
         len_ff     <= len_in;
         type_ff    <= type_in;
         stream_ff  <= stream_in;
      end
   end

endmodule

// ===== design/rtmp_chunk_header_parser.sv =====
// rtmp chunk header parser: one header byte per cycle, one item per completed header
// an accepted byte passes through the byte register and, if it completes a header, the result register before rsp_chan
// throughput: one header byte per cycle; a result item leaves on the header's last byte
// the byte register stalls only when that last byte meets a full, unaccepted result register
// reset (synchronous, active high) clears the byte position, all kept fields and both
// valid flags, so the next byte is taken as the first byte of a header
module rtmp_chunk_header_parser (
   input  logic       clock,
   input  logic       reset,
   chp_req_if.sink    req_chan,
   chp_rsp_if.source  rsp_chan
);
   import chp_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   hdr_result_type     rsp_data_ff;
   hdr_result_type     result;
   logic               done;
   logic               out_free;
   logic               step;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && (!done || out_free);
   assign req_chan.ready = !in_valid_ff || step;
   assign in_valid_in    = req_chan.valid || (in_valid_ff && !step);
   assign rsp_valid_in   = (step && done) || (rsp_valid_ff && !rsp_chan.ready);

   chp_field_state u_fields (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .byte_in (in_byte_ff),
      .done    (done),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_byte_ff <= req_chan.header_byte;
      end
      if (step && done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.chunk_chan  = rsp_data_ff.chunk_chan;
   assign rsp_chan.ts_msec     = rsp_data_ff.ts_msec;
   assign rsp_chan.msg_len     = rsp_data_ff.msg_len;
   assign rsp_chan.msg_type    = rsp_data_ff.msg_type;
   assign rsp_chan.msg_stream  = rsp_data_ff.msg_stream;
   assign rsp_chan.header_form = rsp_data_ff.header_form;
   assign rsp_chan.invalid     = rsp_data_ff.invalid;

endmodule

// ===== design/chp_checker.sv =====
// port-level checks for the rtmp chunk header parser, bound to the top level
module chp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [chp_pkg::TYPE_W-1:0]   rsp_msg_type,
   input logic                         rsp_invalid,
   input logic [chp_pkg::STREAM_W-1:0] rsp_msg_stream
);
   import chp_pkg::*;

   // no result item is shown right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid right after reset");

   // the null flag follows the type shown with it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_invalid == (rsp_msg_type == TYPE_NULL)))
      else $error("invalid flag does not match msg_type");

   // a fresh result item traces back, through the byte and result registers, to the accepted byte that completed it
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result item without a byte accepted two cycles before");

   // a stalled result item stays valid and keeps its msg_stream
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_msg_stream))
      else $error("stalled result item changed");

endmodule

bind rtmp_chunk_header_parser chp_checker u_chp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_msg_type   (rsp_chan.msg_type),
   .rsp_invalid    (rsp_chan.invalid),
   .rsp_msg_stream (rsp_chan.msg_stream)
);
